// ===== src/htf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htf_pkg;

  // Default sizes of the stores.
  localparam int unsigned PendingDepthDef = 32;
  localparam int unsigned EntityWindowDef = 10;
  localparam int unsigned TagNameMaxDef   = 10;
  // Depth of the token queue between the parser and the trim stage.
  localparam int unsigned TokDepth        = 4;

  // Character codes.
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChSlsh = 8'h2F;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChVt   = 8'h0B;
  localparam logic [7:0] ChFf   = 8'h0C;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChApos = 8'h27;

  // One decoded byte, or the end of a text, handed from parser to trim stage.
  // The tail flag marks tokens caused by the final input byte of a text.
  typedef struct packed {
    logic       fin;
    logic       tail;
    logic [7:0] data;
  } tok_t;

  // Lower-case an ASCII letter.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSp) || (c == ChTab) || (c == ChCr) || (c == ChLf) ||
           (c == ChFf) || (c == ChVt);
  endfunction

  // Tag name, first byte in the top byte, zero past its length.
  function automatic logic is_block(input logic [79:0] v, input logic [4:0] n);
    logic r;
    r = 1'b0;
    if (n == 5'd1 && v == {"p", 72'd0}) r = 1'b1;
    if (n == 5'd2) begin
      if (v == {"br", 64'd0} || v == {"li", 64'd0} || v == {"tr", 64'd0} ||
          v == {"h1", 64'd0} || v == {"h2", 64'd0} || v == {"h3", 64'd0} ||
          v == {"h4", 64'd0} || v == {"h5", 64'd0} || v == {"h6", 64'd0} ||
          v == {"ul", 64'd0} || v == {"ol", 64'd0}) begin
        r = 1'b1;
      end
    end
    if (n == 5'd3 && v == {"div", 56'd0}) r = 1'b1;
    if (n == 5'd10 && v == "blockquote") r = 1'b1;
    return r;
  endfunction

  // Entity name, folded, first byte on top; returns match flag and character.
  function automatic logic [8:0] entity_rep(input logic [31:0] v, input logic [4:0] n);
    logic [8:0] r;
    r = 9'd0;
    if (n == 5'd3 && v == {"amp", 8'd0}) r = {1'b1, ChAmp};
    if (n == 5'd2 && v == {"lt", 16'd0}) r = {1'b1, ChLt};
    if (n == 5'd2 && v == {"gt", 16'd0}) r = {1'b1, ChGt};
    if (n == 5'd4 && v == "quot") r = {1'b1, ChQuot};
    if (n == 5'd4 && v == "apos") r = {1'b1, ChApos};
    if (n == 5'd3 && v == {"#39", 8'd0}) r = {1'b1, ChApos};
    if (n == 5'd4 && v == "nbsp") r = {1'b1, ChSp};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/htf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htf_fifo #(
  parameter int unsigned Depth = htf_pkg::TokDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire htf_pkg::tok_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output htf_pkg::tok_t      rd_data_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  htf_pkg::tok_t mem_q [Depth];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd_en) begin
        rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/htf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htf_front #(
  parameter int unsigned EntityWindow = htf_pkg::EntityWindowDef,
  parameter int unsigned TagNameMax   = htf_pkg::TagNameMaxDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            tok_valid_o,
  input  wire logic       tok_ready_i,
  output htf_pkg::tok_t   tok_o
);

  localparam int unsigned QS  = EntityWindow + 2;
  localparam int unsigned QLW = $clog2(QS + 1);
  localparam int unsigned ECW = $clog2(EntityWindow + 1);
  localparam int unsigned NCW = $clog2(TagNameMax + 2);
  localparam int unsigned PNW = $clog2(EntityWindow + 2);

  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_OPEN = 4'b0010,
    MODE_TAG  = 4'b0100,
    MODE_ENT  = 4'b1000
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [7:0]     rq_q [QS];
  logic [7:0]     rq_d [QS];
  logic [QLW-1:0] rlen_q, rlen_d;
  logic [7:0]     hold_q [EntityWindow];
  logic [7:0]     hold_d [EntityWindow];
  logic [ECW-1:0] ecnt_q, ecnt_d;
  logic [7:0]     name_q [TagNameMax];
  logic [7:0]     name_d [TagNameMax];
  logic [NCW-1:0] ncnt_q, ncnt_d;
  logic           closed_q, closed_d;
  logic           emitted_q, emitted_d;
  logic           prevnl_q, prevnl_d;
  logic           last_q, last_d;

  logic           act, popped, parse, emit, fin, semi_fail, tail;
  logic [7:0]     b, eb;
  logic [7:0]     pv [EntityWindow + 1];
  logic [PNW-1:0] pn;
  logic [7:0]     base [QS];
  logic [QLW-1:0] base_len;
  logic [79:0]    nv;
  logic [31:0]    ev;
  logic [8:0]     rep;
  logic [QLW:0]   sum_len;

  assign in_ready_o  = (rlen_q == '0) && !last_q && tok_ready_i;
  assign act         = tok_ready_i && ((rlen_q != '0) || last_q || in_valid_i);
  assign tok_valid_o = act && (emit || fin);
  assign tok_o       = '{fin: fin, tail: tail, data: eb};

  // Packed views of the tag name and the entity name for matching.
  always_comb begin
    nv = '0;
    for (int i = 0; i < 10; i++) begin
      if (NCW'(i) < ncnt_q) nv[79 - 8*i -: 8] = name_q[i];
    end
    ev = '0;
    for (int i = 0; i < 4; i++) begin
      if (ECW'(i) < ecnt_q) ev[31 - 8*i -: 8] = htf_pkg::fold(hold_q[i]);
    end
    rep = htf_pkg::entity_rep(ev, 5'(ecnt_q));
  end

  // Parser: one byte per cycle while the token queue has room, from the replay queue first, then the input.
  always_comb begin
    mode_d    = mode_q;
    hold_d    = hold_q;
    ecnt_d    = ecnt_q;
    name_d    = name_q;
    ncnt_d    = ncnt_q;
    closed_d  = closed_q;
    emitted_d = emitted_q;
    prevnl_d  = prevnl_q;
    last_d    = last_q;
    emit      = 1'b0;
    eb        = '0;
    fin       = 1'b0;
    pn        = '0;
    semi_fail = 1'b0;
    popped    = 1'b0;
    parse     = 1'b0;
    tail      = last_q;
    b         = in_byte_i;

    if (act) begin
      if (rlen_q != '0) begin
        b      = rq_q[0];
        popped = 1'b1;
        parse  = 1'b1;
      end else if (last_q) begin
        if (mode_q == MODE_ENT) begin
          // End inside an entity: emit the ampersand and replay the name.
          emit   = 1'b1;
          eb     = htf_pkg::ChAmp;
          pn     = PNW'(ecnt_q);
          mode_d = MODE_TEXT;
          ecnt_d = '0;
        end else begin
          fin       = 1'b1;
          mode_d    = MODE_TEXT;
          ncnt_d    = '0;
          closed_d  = 1'b0;
          ecnt_d    = '0;
          emitted_d = 1'b0;
          prevnl_d  = 1'b0;
          last_d    = 1'b0;
        end
      end else begin
        parse  = 1'b1;
        last_d = in_last_i;
        tail   = in_last_i;
      end
    end

    if (parse) begin
      case (mode_q)
        MODE_OPEN, MODE_TAG: begin
          mode_d = MODE_TAG;
          if (b == htf_pkg::ChGt) begin
            if (ncnt_q <= NCW'(TagNameMax) &&
                htf_pkg::is_block(nv, 5'(ncnt_q)) && emitted_q && !prevnl_q) begin
              emit = 1'b1;
              eb   = htf_pkg::ChLf;
            end
            mode_d   = MODE_TEXT;
            ncnt_d   = '0;
            closed_d = 1'b0;
          end else if (mode_q == MODE_TAG && closed_q) begin
            closed_d = 1'b1;
          end else if (b == htf_pkg::ChSp ||
                       (mode_q == MODE_TAG && b == htf_pkg::ChSlsh)) begin
            closed_d = 1'b1;
          end else if (b != htf_pkg::ChSlsh) begin
            for (int i = 0; i < TagNameMax; i++) begin
              if (NCW'(i) == ncnt_q) name_d[i] = htf_pkg::fold(b);
            end
            if (ncnt_q <= NCW'(TagNameMax)) ncnt_d = ncnt_q + 1'b1;
          end
        end
        MODE_ENT: begin
          if (b == htf_pkg::ChSemi) begin
            mode_d = MODE_TEXT;
            ecnt_d = '0;
            emit   = 1'b1;
            if (rep[8]) begin
              eb = rep[7:0];
            end else begin
              eb        = htf_pkg::ChAmp;
              semi_fail = 1'b1;
              pn        = PNW'(ecnt_q) + 1'b1;
            end
          end else begin
            for (int i = 0; i < EntityWindow; i++) begin
              if (ECW'(i) == ecnt_q) hold_d[i] = b;
            end
            ecnt_d = ecnt_q + 1'b1;
            if (ecnt_q + 1'b1 >= ECW'(EntityWindow)) begin
              emit   = 1'b1;
              eb     = htf_pkg::ChAmp;
              pn     = PNW'(EntityWindow);
              mode_d = MODE_TEXT;
              ecnt_d = '0;
            end
          end
        end
        default: begin
          if (b == htf_pkg::ChLt) begin
            mode_d   = MODE_OPEN;
            ncnt_d   = '0;
            closed_d = 1'b0;
          end else if (b == htf_pkg::ChAmp) begin
            mode_d = MODE_ENT;
            ecnt_d = '0;
          end else begin
            emit = 1'b1;
            eb   = b;
          end
        end
      endcase
    end

    if (emit) begin
      emitted_d = 1'b1;
      prevnl_d  = (eb == htf_pkg::ChLf);
    end
  end

  // Replay queue: pop the head, then push the held entity bytes, and the semicolon of a failed match, in front.
  always_comb begin
    for (int i = 0; i <= EntityWindow; i++) begin
      if (semi_fail && PNW'(i) == PNW'(ecnt_q)) begin
        pv[i] = htf_pkg::ChSemi;
      end else if (i < EntityWindow) begin
        pv[i] = hold_d[i];
      end else begin
        pv[i] = '0;
      end
    end
    for (int i = 0; i < QS; i++) begin
      if (popped) begin
        base[i] = (i + 1 < QS) ? rq_q[i + 1] : 8'h00;
      end else begin
        base[i] = rq_q[i];
      end
    end
    base_len = rlen_q - QLW'(popped);
    for (int i = 0; i < QS; i++) begin
      rq_d[i] = '0;
      if (QLW'(i) < QLW'(pn)) begin
        for (int k = 0; k <= EntityWindow; k++) begin
          if (k == i) rq_d[i] = pv[k];
        end
      end else begin
        for (int k = 0; k < QS; k++) begin
          if (QLW'(k) + QLW'(pn) == QLW'(i)) rq_d[i] = base[k];
        end
      end
    end
    sum_len = (QLW+1)'(base_len) + (QLW+1)'(pn);
    rlen_d  = (sum_len > (QLW+1)'(QS)) ? QLW'(QS) : sum_len[QLW-1:0];
  end

  // Byte stores.
  always_ff @(posedge clk_i) begin
    rq_q   <= rq_d;
    hold_q <= hold_d;
    name_q <= name_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_TEXT;
      rlen_q    <= '0;
      ecnt_q    <= '0;
      ncnt_q    <= '0;
      closed_q  <= 1'b0;
      emitted_q <= 1'b0;
      prevnl_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      rlen_q    <= rlen_d;
      ecnt_q    <= ecnt_d;
      ncnt_q    <= ncnt_d;
      closed_q  <= closed_d;
      emitted_q <= emitted_d;
      prevnl_q  <= prevnl_d;
      last_q    <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/htf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htf_back #(
  parameter int unsigned PendingDepth = htf_pkg::PendingDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_valid_i,
  output logic               tok_ready_o,
  input  wire htf_pkg::tok_t tok_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_bvalid_o,
  output logic               out_end_o,
  output logic               out_ovf_o
);

  localparam int unsigned PW = (PendingDepth > 1) ? $clog2(PendingDepth) : 1;
  localparam int unsigned CW = $clog2(PendingDepth + 1);

  logic [7:0]    pmem_q [PendingDepth];
  logic [7:0]    head_q;
  logic [PW-1:0] prd_q, prd_d, pwr_q, pwr_d;
  logic [CW-1:0] pcnt_q, pcnt_d;
  logic [1:0]    run_q, run_d;
  logic          lead_q, lead_d;
  logic          hv_q, hv_d;
  logic [7:0]    hb_q, hb_d;
  logic          hovf_q, hovf_d;
  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d;
  logic          obv_q, obv_d, oend_q, oend_d, oovf_q, oovf_d;

  logic          out_free, prod, povf, consume, push, pop, fire;
  logic [7:0]    pb, b;
  logic          ws;

  assign out_free     = !ov_q || out_ready_i;
  assign b            = tok_i.data;
  assign ws           = htf_pkg::is_ws(b);
  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign out_bvalid_o = obv_q;
  assign out_end_o    = oend_q;
  assign out_ovf_o    = oovf_q;

  // Trim stage: decide what this token produces.
  always_comb begin
    prod    = 1'b0;
    pb      = b;
    povf    = 1'b0;
    consume = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    if (tok_valid_i && !tok_i.fin) begin
      if (b == htf_pkg::ChCr) begin
        consume = 1'b1;
      end else if (b == htf_pkg::ChLf && run_q == 2'd2) begin
        consume = 1'b1;
      end else if (!lead_q) begin
        consume = 1'b1;
        prod    = !ws;
      end else if (ws) begin
        consume = 1'b1;
        push    = 1'b1;
        if (pcnt_q == CW'(PendingDepth)) begin
          prod = 1'b1;
          pb   = head_q;
          povf = 1'b1;
          pop  = 1'b1;
        end
      end else if (pcnt_q != '0) begin
        prod = 1'b1;
        pb   = head_q;
        pop  = 1'b1;
      end else begin
        prod    = 1'b1;
        consume = 1'b1;
      end
    end
    fire = tok_valid_i && (out_free || (!prod && !tok_i.fin));
  end

  assign tok_ready_o = fire && (consume || tok_i.fin);

  // Next state of counters, pointers and output registers. Bytes caused by the
  // final input byte of a text are held back by one beat so that the last one
  // can carry the end flag.
  always_comb begin
    prd_d  = prd_q;
    pwr_d  = pwr_q;
    pcnt_d = pcnt_q;
    run_d  = run_q;
    lead_d = lead_q;
    hv_d   = hv_q;
    hb_d   = hb_q;
    hovf_d = hovf_q;
    ov_d   = ov_q && !out_ready_i;
    ob_d   = ob_q;
    obv_d  = obv_q;
    oend_d = oend_q;
    oovf_d = oovf_q;
    if (fire) begin
      if (tok_i.fin) begin
        ov_d   = 1'b1;
        ob_d   = hv_q ? hb_q : 8'h00;
        obv_d  = hv_q;
        oovf_d = hv_q && hovf_q;
        oend_d = 1'b1;
        hv_d   = 1'b0;
        prd_d  = '0;
        pwr_d  = '0;
        pcnt_d = '0;
        run_d  = '0;
        lead_d = 1'b0;
      end else begin
        if (prod) begin
          if (tok_i.tail) begin
            if (hv_q) begin
              ov_d   = 1'b1;
              ob_d   = hb_q;
              obv_d  = 1'b1;
              oovf_d = hovf_q;
              oend_d = 1'b0;
            end
            hv_d   = 1'b1;
            hb_d   = pb;
            hovf_d = povf;
          end else begin
            ov_d   = 1'b1;
            ob_d   = pb;
            obv_d  = 1'b1;
            oovf_d = povf;
            oend_d = 1'b0;
          end
        end
        if (consume && b != htf_pkg::ChCr) begin
          run_d = (b == htf_pkg::ChLf) ? run_q + 1'b1 : 2'd0;
          if (!ws) lead_d = 1'b1;
        end
        if (pop) begin
          prd_d = (prd_q == PW'(PendingDepth - 1)) ? '0 : prd_q + 1'b1;
        end
        if (push) begin
          pwr_d = (pwr_q == PW'(PendingDepth - 1)) ? '0 : pwr_q + 1'b1;
        end
        if (push && !pop) begin
          pcnt_d = pcnt_q + 1'b1;
        end else if (pop && !push) begin
          pcnt_d = pcnt_q - 1'b1;
        end
      end
    end
  end

  // Pending whitespace memory with a registered head read.
  always_ff @(posedge clk_i) begin
    if (fire && push) begin
      pmem_q[pwr_q] <= b;
    end
    if (fire && push && pwr_q == prd_d) begin
      head_q <= b;
    end else begin
      head_q <= pmem_q[prd_d];
    end
    hb_q   <= hb_d;
    hovf_q <= hovf_d;
    ob_q   <= ob_d;
    obv_q  <= obv_d;
    oend_q <= oend_d;
    oovf_q <= oovf_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_q  <= '0;
      pwr_q  <= '0;
      pcnt_q <= '0;
      run_q  <= '0;
      lead_q <= 1'b0;
      hv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      prd_q  <= prd_d;
      pwr_q  <= pwr_d;
      pcnt_q <= pcnt_d;
      run_q  <= run_d;
      lead_q <= lead_d;
      hv_q   <= hv_d;
      ov_q   <= ov_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/html_to_text_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HTML to plain text filter. Each input beat carries one byte of HTML, with
// tlast on the final byte of a text. Tags are stripped (block tags become a
// newline), the common named entities are decoded, CR is dropped, the third
// newline of a run and every fourth one after it are dropped, and leading and
// trailing whitespace is trimmed. Every text ends in exactly one output beat
// with tlast; tuser[0] clear on that beat means a bare end marker, and
// tuser[1] flags whitespace released early because the pending store was
// full. Output bytes caused by the final input byte of a text are held back
// by one beat so that the last of them can carry tlast. A failed entity sends
// its held bytes, plus the semicolon when one ended the entity, through the
// parser again from its replay queue, and no new input byte is taken until
// that queue is empty. A byte that ends a whitespace run waits in the trim
// stage until every held whitespace byte before it has been released. Parser
// and trim stage are joined by a short token queue, so each stalls on its own.
module html_to_text_filter_unit #(
  parameter int unsigned PENDING_DEPTH = htf_pkg::PendingDepthDef,
  parameter int unsigned ENTITY_WINDOW = htf_pkg::EntityWindowDef,
  parameter int unsigned TAG_NAME_MAX  = htf_pkg::TagNameMaxDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser_o,   // [0] byte_valid, [1] trim_overflow
  output logic            m_axis_tlast_o    // text_end
);

  logic          tok_wvalid, tok_wready, tok_rvalid, tok_rready;
  htf_pkg::tok_t tok_w, tok_r;

  // Parser.
  htf_front #(
    .EntityWindow(ENTITY_WINDOW),
    .TagNameMax  (TAG_NAME_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .tok_valid_o(tok_wvalid),
    .tok_ready_i(tok_wready),
    .tok_o      (tok_w)
  );

  // Token queue.
  htf_fifo #(
    .Depth(htf_pkg::TokDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(tok_wvalid),
    .wr_ready_o(tok_wready),
    .wr_data_i (tok_w),
    .rd_valid_o(tok_rvalid),
    .rd_ready_i(tok_rready),
    .rd_data_o (tok_r)
  );

  // Trim stage and output register.
  htf_back #(
    .PendingDepth(PENDING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_rvalid),
    .tok_ready_o (tok_rready),
    .tok_i       (tok_r),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_bvalid_o(m_axis_tuser_o[0]),
    .out_end_o   (m_axis_tlast_o),
    .out_ovf_o   (m_axis_tuser_o[1])
  );

endmodule

`default_nettype wire
